### hdl/olist_pkg.sv
// Shared types, codes and constants for the ordered list engine.
package olist_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int CNT_W        = 7;
	localparam int POS_W        = 7;
	localparam int DATA_W       = 32;

	// Operation codes carried in the mode field
	typedef enum logic [2:0] {
		OP_INSERT     = 3'd0,
		OP_ERASE_POS  = 3'd1,
		OP_ERASE_VAL  = 3'd2,
		OP_CHANGE_POS = 3'd3,
		OP_CHANGE_VAL = 3'd4,
		OP_FILL       = 3'd5,
		OP_READ       = 3'd6
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_BADPOS  = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_BADFILL = 2'd3
	} stat_t;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_FINAL
	} state_t;

	typedef struct packed {
		logic [2:0]               mode;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] new_value;
		logic [CNT_W-1:0]         fill_count;
	} req_word_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] element_value;
		logic [CNT_W-1:0]         match_total;
		logic [CNT_W-1:0]         list_count;
	} rsp_word_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic start;
		logic issue;
		logic finish;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic rem_zero;
		logic pend;
		logic rsp_busy;
	} sts_t;

endpackage

### hdl/olist_ctrl.sv
// Sequencing state machine of the ordered list engine.
module olist_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  olist_pkg::sts_t   sts,
	output olist_pkg::cmd_t   cmd
);
	import olist_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		req_stall  = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.start = 1'b1;
				state_d   = S_SCAN;
			end
			S_SCAN: begin
				// one store read per cycle until the walk is done, then let the
				// last read data retire
				if (!sts.rem_zero) begin
					cmd.issue = 1'b1;
				end else if (!sts.pend) begin
					state_d = S_FINAL;
				end
			end
			S_FINAL: begin
				if (!sts.rsp_busy) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### hdl/olist_dp.sv
// Datapath of the ordered list engine: element store, count, walk counters, result register.
module olist_dp #(
	parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  olist_pkg::req_word_t  req_word,
	input  olist_pkg::cmd_t       cmd,
	output olist_pkg::sts_t       sts,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output olist_pkg::rsp_word_t  rsp_word
);
	import olist_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	// element store
	logic signed [DATA_W-1:0] mem_q [CAPACITY];

	req_word_t                req_q;
	logic [CNT_W-1:0]         count_q;
	stat_t                    status_q;
	logic signed [DATA_W-1:0] elem_q;
	logic [CNT_W-1:0]         match_q;
	logic [CNT_W-1:0]         w_q;
	logic [CNT_W-1:0]         rem_q;
	logic [AW-1:0]            rd_idx_q;
	logic                     pend_q;
	logic [AW-1:0]            pend_addr_q;
	logic signed [DATA_W-1:0] rd_data_q;
	logic                     rsp_valid_q;
	rsp_word_t                rsp_q;

	op_t                      op;
	stat_t                    chk_status;
	logic [CNT_W-1:0]         chk_rem;
	logic [AW-1:0]            chk_idx;
	logic                     hit;
	logic                     we;
	logic [AW-1:0]            waddr;
	logic signed [DATA_W-1:0] wdata;
	logic                     cap_elem;
	logic                     inc_match;
	logic                     inc_w;
	logic [CNT_W-1:0]         next_count;
	rsp_word_t                rsp_d;

	assign op  = op_t'(req_q.mode);
	assign hit = (rd_data_q == req_q.value);

	// Range checks and walk setup for the captured word
	always_comb begin
		chk_status = STAT_OK;
		chk_rem    = '0;
		chk_idx    = '0;
		unique case (op)
			OP_INSERT: begin
				if (req_q.position > count_q) begin
					chk_status = STAT_BADPOS;
				end else if (count_q >= CAP_C) begin
					chk_status = STAT_FULL;
				end else begin
					// walk down from the top, each slot moves up one
					chk_rem = count_q - req_q.position;
					chk_idx = AW'(count_q - CNT_W'(1));
				end
			end
			OP_ERASE_POS, OP_CHANGE_POS, OP_READ: begin
				if (req_q.position >= count_q) begin
					chk_status = STAT_BADPOS;
				end else begin
					chk_rem = (op == OP_ERASE_POS) ? (count_q - req_q.position) : CNT_W'(1);
					chk_idx = AW'(req_q.position);
				end
			end
			OP_ERASE_VAL, OP_CHANGE_VAL: begin
				chk_rem = count_q;
			end
			OP_FILL: begin
				if (req_q.fill_count > CAP_C) begin
					chk_status = STAT_BADFILL;
				end else begin
					chk_rem = req_q.fill_count;
				end
			end
			default: begin
			end
		endcase
	end

	// Store write port: final insert write, else action on returned read data
	always_comb begin
		we        = 1'b0;
		waddr     = pend_addr_q;
		wdata     = rd_data_q;
		cap_elem  = 1'b0;
		inc_match = 1'b0;
		inc_w     = 1'b0;
		priority if (cmd.finish) begin
			if (op == OP_INSERT && status_q == STAT_OK) begin
				we    = 1'b1;
				waddr = AW'(req_q.position);
				wdata = req_q.value;
			end
		end else if (pend_q) begin
			unique case (op)
				OP_INSERT: begin
					we    = 1'b1;
					waddr = pend_addr_q + AW'(1);
				end
				OP_ERASE_POS: begin
					if (pend_addr_q == AW'(req_q.position)) begin
						cap_elem = 1'b1;
					end else begin
						we    = 1'b1;
						waddr = pend_addr_q - AW'(1);
					end
				end
				OP_ERASE_VAL: begin
					// compact survivors down to the write index
					if (hit) begin
						inc_match = 1'b1;
					end else begin
						we    = 1'b1;
						waddr = AW'(w_q);
						inc_w = 1'b1;
					end
				end
				OP_CHANGE_POS: begin
					cap_elem = 1'b1;
					we       = 1'b1;
					wdata    = req_q.value;
				end
				OP_CHANGE_VAL: begin
					if (hit) begin
						inc_match = 1'b1;
						we        = 1'b1;
						wdata     = req_q.new_value;
					end
				end
				OP_FILL: begin
					we    = 1'b1;
					wdata = req_q.value;
				end
				OP_READ: begin
					cap_elem = 1'b1;
				end
				default: begin
				end
			endcase
		end else begin
			// no read data returning: store left alone
		end
	end

	// Count after the operation
	always_comb begin
		next_count = count_q;
		if (status_q == STAT_OK) begin
			unique case (op)
				OP_INSERT:    next_count = count_q + CNT_W'(1);
				OP_ERASE_POS: next_count = count_q - CNT_W'(1);
				OP_ERASE_VAL: next_count = w_q;
				OP_FILL:      next_count = req_q.fill_count;
				default:      next_count = count_q;
			endcase
		end
	end

	always_comb begin
		rsp_d.status        = status_q;
		rsp_d.element_value = elem_q;
		rsp_d.match_total   = match_q;
		rsp_d.list_count    = next_count;
	end

	// Element store, single read and single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (cmd.issue) begin
			rd_data_q <= mem_q[rd_idx_q];
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			status_q    <= STAT_OK;
			rem_q       <= '0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			pend_q <= cmd.issue;
			if (cmd.start) begin
				status_q <= chk_status;
				rem_q    <= chk_rem;
			end else if (cmd.issue) begin
				rem_q <= rem_q - CNT_W'(1);
			end
			if (cmd.finish) begin
				count_q     <= next_count;
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_word;
		end
		if (cmd.start) begin
			rd_idx_q <= chk_idx;
			elem_q   <= '0;
			match_q  <= '0;
			w_q      <= '0;
		end else begin
			if (cmd.issue) begin
				rd_idx_q <= (op == OP_INSERT) ? (rd_idx_q - AW'(1)) : (rd_idx_q + AW'(1));
			end
			if (cap_elem) begin
				elem_q <= rd_data_q;
			end
			if (inc_match) begin
				match_q <= match_q + CNT_W'(1);
			end
			if (inc_w) begin
				w_q <= w_q + CNT_W'(1);
			end
		end
		if (cmd.issue) begin
			pend_addr_q <= rd_idx_q;
		end
		if (cmd.finish) begin
			rsp_q <= rsp_d;
		end
	end

	assign sts.rem_zero = (rem_q == '0);
	assign sts.pend     = pend_q;
	assign sts.rsp_busy = rsp_valid_q && rsp_stall;
	assign rsp_valid    = rsp_valid_q;
	assign rsp_word     = rsp_q;

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("list count above capacity");

	a_err_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(status_q != STAT_OK) |-> !we)
		else $error("store written by a rejected operation");

	a_issue_rem: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (rem_q != '0))
		else $error("read issued past the end of the walk");

	a_finish_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !pend_q)
		else $error("result taken with read data still in flight");

endmodule

### hdl/ordered_list_engine.sv
// Top level of the ordered list engine: controller and datapath.
//
//   channel | valid     | stall     | word
//   --------+-----------+-----------+----------------------------------------------
//   request | req_valid | req_stall | req_word: mode, position, value, new_value, fill_count
//   result  | rsp_valid | rsp_stall | rsp_word: status, element_value, match_total, list_count
//
// An operation walks n store slots: count - position for insert and erase at position,
// count for the value operations, fill_count for fill, one for change at position and
// read. No slot is walked for errors, empty list scans, zero fill or the spare mode.
// The engine returns to idle for the next word as the result is loaded.
// The walk is set by the single read port of the element store, one slot a cycle.
// Reset clears the count and control state; store contents are left as they are.
// A new word is accepted while an earlier result waits in the result register; the
// engine holds in its last step until that register is free.
module ordered_list_engine #(
	parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  olist_pkg::req_word_t  req_word,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output olist_pkg::rsp_word_t  rsp_word
);
	import olist_pkg::*;

	cmd_t cmd;
	sts_t sts;

	olist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	olist_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_word  (req_word),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word)
	);

endmodule
